/* src/tsds_pkg.sv */
// Package for the transparent sprite depth sorter: payload structs, register
// indexes, sizes and the controller/datapath command and status structs.
// No dependencies.
package tsds_pkg;

	localparam int SLOTS    = 64;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CAPACITY = SLOTS - 1;

	localparam logic [2:0] REG_CAMERA_X = 3'd0;
	localparam logic [2:0] REG_CAMERA_Y = 3'd1;
	localparam logic [2:0] REG_CAMERA_Z = 3'd2;
	localparam logic [2:0] REG_VIEW_X   = 3'd3;
	localparam logic [2:0] REG_VIEW_Y   = 3'd4;
	localparam logic [2:0] REG_VIEW_Z   = 3'd5;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef struct packed {
		logic              action;
		logic [7:0]        sprite_kind;
		logic [7:0]        sprite_alpha;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        out_kind;
		logic [7:0]        out_alpha;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_depth;
		logic              is_last;
	} out_item_t;

	// stored entry minus its key
	typedef struct packed {
		logic [7:0]  kind;
		logic [7:0]  alpha;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} entry_t;

	typedef struct packed {
		logic             load_item;   // capture request payload
		logic [1:0]       mul_axis;    // axis for depth multiply
		logic             mul_go;      // register one axis product
		logic             acc_clear;
		logic             store;       // write entry and key
		logic             init_order;  // order[idx] = idx
		logic             ord_read;    // register order[idx], order[idx+1]
		logic             cmp_read;    // read keys at the registered order pair
		logic             cmp_swap;    // conditional swap at idx
		logic             emit_read;   // read entry at the registered order[idx]
		logic [IDX_W-1:0] idx;
		logic             clear_count;
	} dp_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] count;
		logic             action;
	} dp_stat_t;

	// ((a>>>7)*(b>>>7)) low 32 bits, then >>>2
	function automatic logic [31:0] fpmul_post(input logic [63:0] p);
		logic [31:0] lo;
		lo = p[31:0];
		return 32'($signed(lo) >>> 2);
	endfunction

endpackage

/* src/tsds_datapath.sv */
// Datapath of the sprite depth sorter: item register, depth key unit,
// entry and key memories, sort order table and output register.
// Depends on tsds_pkg.
module tsds_datapath (
	input  logic                clk,
	input  tsds_pkg::in_item_t  item,
	input  tsds_pkg::dp_cmd_t   cmd,
	input  logic [31:0]         cam_x,
	input  logic [31:0]         cam_y,
	input  logic [31:0]         cam_z,
	input  logic [31:0]         view_x,
	input  logic [31:0]         view_y,
	input  logic [31:0]         view_z,
	input  logic                arst_n,
	output tsds_pkg::dp_stat_t  stat,
	output tsds_pkg::entry_t    rd_entry,
	output logic [31:0]         rd_key
);
	import tsds_pkg::*;

	in_item_t          item_q;
	logic [IDX_W-1:0]  count_q;
	logic [63:0]       prod_q;
	logic [31:0]       acc_q;
	logic [31:0]       diff, vsel;
	entry_t            entry_mem [SLOTS];
	logic [31:0]       key_mem   [SLOTS];
	logic [IDX_W-1:0]  order_q   [SLOTS];
	logic [IDX_W-1:0]  ord_a_q, ord_b_q;
	logic [31:0]       key_a_q, key_b_q;
	logic [IDX_W-1:0]  idx_nx;
	logic              swap_hit;

	assign idx_nx = cmd.idx + IDX_W'(1);

	always_comb begin
		unique case (cmd.mul_axis)
			2'd0:    begin diff = item_q.pos_x - cam_x; vsel = view_x; end
			2'd1:    begin diff = item_q.pos_y - cam_y; vsel = view_y; end
			default: begin diff = item_q.pos_z - cam_z; vsel = view_z; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= item;
		if (cmd.mul_go)
			prod_q <= 64'($signed(32'($signed(diff) >>> 7)) *
				$signed(32'($signed(vsel) >>> 7)));
		if (cmd.acc_clear) acc_q <= '0;
		else if (cmd.store || cmd.mul_go) acc_q <= acc_q + fpmul_post(prod_q);
		if (cmd.store) begin
			entry_mem[count_q] <= '{item_q.sprite_kind, item_q.sprite_alpha,
				item_q.pos_x, item_q.pos_y, item_q.pos_z};
			key_mem[count_q] <= 32'd0 - (acc_q + fpmul_post(prod_q));
		end
		if (cmd.init_order) order_q[cmd.idx] <= cmd.idx;
		if (cmd.ord_read) begin
			ord_a_q <= order_q[cmd.idx];
			ord_b_q <= order_q[idx_nx];
		end
		if (cmd.cmp_read) begin
			key_a_q <= key_mem[ord_a_q];
			key_b_q <= key_mem[ord_b_q];
		end
		if (cmd.cmp_swap && swap_hit) begin
			order_q[cmd.idx] <= ord_b_q;
			order_q[idx_nx]  <= ord_a_q;
		end
		if (cmd.emit_read) begin
			rd_entry <= entry_mem[ord_a_q];
			rd_key   <= key_mem[ord_a_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.clear_count) count_q <= '0;
		else if (cmd.store) count_q <= count_q + IDX_W'(1);
	end

	assign swap_hit = $signed(key_a_q) < $signed(key_b_q);
	assign stat = '{count_q, item_q.action};
endmodule

/* src/tsds_ctrl.sv */
// Controller of the sprite depth sorter: sequences add, bubble sort and
// emission over the datapath. Depends on tsds_pkg.
module tsds_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_last,
	input  tsds_pkg::dp_stat_t stat,
	output tsds_pkg::dp_cmd_t  cmd
);
	import tsds_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_MX = 4'd2, S_MY = 4'd3,
		S_MZ = 4'd4, S_ST = 4'd5, S_INIT = 4'd6, S_CR = 4'd7, S_CS = 4'd8,
		S_ER = 4'd9, S_OUT = 4'd10, S_OR = 4'd11, S_EO = 4'd12;

	logic [3:0]       state_q;
	logic [IDX_W-1:0] idx_q, pass_q, last_idx;

	assign last_idx = stat.count - IDX_W'(1);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_last = (idx_q == last_idx);

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		unique case (state_q)
			S_IDLE: cmd.load_item = in_valid;
			S_MX:   begin cmd.mul_axis = 2'd0; cmd.mul_go = 1'b1; cmd.acc_clear = 1'b1; end
			S_MY:   begin cmd.mul_axis = 2'd1; cmd.mul_go = 1'b1; end
			S_MZ:   begin cmd.mul_axis = 2'd2; cmd.mul_go = 1'b1; end
			S_ST:   cmd.store = 1'b1;
			S_INIT: cmd.init_order = 1'b1;
			S_OR:   cmd.ord_read = 1'b1;
			S_CR:   cmd.cmp_read = 1'b1;
			S_CS:   cmd.cmp_swap = 1'b1;
			S_EO:   cmd.ord_read = 1'b1;
			S_ER:   cmd.emit_read = 1'b1;
			S_OUT:  cmd.clear_count = out_ready && out_last;
			default: cmd.idx = idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			pass_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DEC;
				S_DEC: begin
					idx_q <= '0;
					pass_q <= '0;
					priority if (stat.action == ACT_ADD)
						state_q <= (32'(stat.count) >= CAPACITY) ? S_IDLE : S_MX;
					else if (stat.count == '0) state_q <= S_IDLE;
					else state_q <= S_INIT;
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_MZ;
				S_MZ: state_q <= S_ST;
				S_ST: state_q <= S_IDLE;
				S_INIT: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == last_idx) begin
						idx_q <= '0;
						state_q <= (stat.count == IDX_W'(1)) ? S_EO : S_OR;
					end
				end
				S_OR: state_q <= S_CR;
				S_CR: state_q <= S_CS;
				S_CS: begin
					// advance compare index; a pass ends at count-2
					if (idx_q + IDX_W'(2) == stat.count) begin
						idx_q <= '0;
						if (pass_q + IDX_W'(2) == stat.count) state_q <= S_EO;
						else begin pass_q <= pass_q + IDX_W'(1); state_q <= S_OR; end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						state_q <= S_OR;
					end
				end
				S_EO: state_q <= S_ER;
				S_ER: state_q <= S_OUT;
				S_OUT: if (out_ready) begin
					if (out_last) state_q <= S_IDLE;
					else begin idx_q <= idx_q + IDX_W'(1); state_q <= S_EO; end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* src/transparent_sprite_depth_sorter.sv */
// Transparent sprite depth sorter: an add request runs one multiply per axis
// into a shared registered multiplier, then a store (an add to a full store
// is dropped); a flush decodes and fills the order table, then bubble sorts
// (a registered read of the order pair, a key pair read and a compare per
// step) and emits each sprite by an order read, an entry read and a result
// that may stall. One request is handled at a time.
// Depends on tsds_pkg, tsds_ctrl and tsds_datapath.
module transparent_sprite_depth_sorter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsds_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tsds_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import tsds_pkg::*;

	logic [31:0] cam_x_q, cam_y_q, cam_z_q, view_x_q, view_y_q, view_z_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;
	entry_t      rd_entry;
	logic [31:0] rd_key;
	logic        last;
	logic [2:0]  reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0; cam_y_q <= '0; cam_z_q <= '0;
			view_x_q <= '0; view_y_q <= '0; view_z_q <= 32'd65536;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_CAMERA_X: cam_x_q <= pwdata;
				REG_CAMERA_Y: cam_y_q <= pwdata;
				REG_CAMERA_Z: cam_z_q <= pwdata;
				REG_VIEW_X:   view_x_q <= pwdata;
				REG_VIEW_Y:   view_y_q <= pwdata;
				REG_VIEW_Z:   view_z_q <= pwdata;
				default:      cam_x_q <= cam_x_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CAMERA_X: prdata = cam_x_q;
			REG_CAMERA_Y: prdata = cam_y_q;
			REG_CAMERA_Z: prdata = cam_z_q;
			REG_VIEW_X:   prdata = view_x_q;
			REG_VIEW_Y:   prdata = view_y_q;
			REG_VIEW_Z:   prdata = view_z_q;
			default:      prdata = '0;
		endcase
	end

	tsds_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.out_last(last), .stat, .cmd
	);

	tsds_datapath u_dp (
		.clk, .item(in_data), .cmd, .cam_x(cam_x_q), .cam_y(cam_y_q),
		.cam_z(cam_z_q), .view_x(view_x_q), .view_y(view_y_q),
		.view_z(view_z_q), .arst_n, .stat, .rd_entry, .rd_key
	);

	assign out_data = '{rd_entry.kind, rd_entry.alpha, rd_entry.x, rd_entry.y,
		rd_entry.z, rd_key, last};

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken during emission");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stat.count) <= CAPACITY) else $error("store overfilled");
	a_empty_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> stat.count == '0)
		else $error("store not emptied after batch");
endmodule

/* tb/transparent_sprite_depth_sorter_tb.sv */
// Testbench for the transparent sprite depth sorter: drives add and flush
// requests and APB register writes, predicts the depth-ordered batches.
// Depends on tsds_pkg and transparent_sprite_depth_sorter.
module transparent_sprite_depth_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsds_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	transparent_sprite_depth_sorter u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [31:0] cam [3];
	logic [31:0] view [3];
	entry_t batch [$];
	logic [31:0] batch_key [$];
	out_item_t sorted_q [$];
	int errors = 0;
	int flushes = 0;
	int sprites_out = 0;
	bit stim_done = 1'b0;

	function automatic logic [31:0] asr(input logic [31:0] v, input int n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] scale_mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = 64'(asr(a, 7)) * 64'(asr(b, 7));
		return asr(p[31:0], 2);
	endfunction

	function automatic logic [31:0] depth_key(input in_item_t it);
		logic [31:0] s;
		s = scale_mul(it.pos_x - cam[0], view[0]) + scale_mul(it.pos_y - cam[1], view[1])
			+ scale_mul(it.pos_z - cam[2], view[2]);
		return 32'd0 - s;
	endfunction

	task automatic predict(input in_item_t it);
		int n;
		int ord [$];
		int t;
		out_item_t o;
		if (it.action == ACT_ADD) begin
			if (batch.size() < CAPACITY) begin
				batch.push_back('{it.sprite_kind, it.sprite_alpha, it.pos_x, it.pos_y, it.pos_z});
				batch_key.push_back(depth_key(it));
			end
		end else begin
			n = batch.size();
			for (int i = 0; i < n; i++) ord.push_back(i);
			// swap only on strictly smaller key keeps arrival order for ties
			for (int i = 0; i + 1 < n; i++)
				for (int k = 0; k + 1 < n; k++)
					if ($signed(batch_key[ord[k]]) < $signed(batch_key[ord[k+1]])) begin
						t = ord[k]; ord[k] = ord[k+1]; ord[k+1] = t;
					end
			for (int k = 0; k < n; k++) begin
				o.out_kind = batch[ord[k]].kind;
				o.out_alpha = batch[ord[k]].alpha;
				o.out_x = batch[ord[k]].x;
				o.out_y = batch[ord[k]].y;
				o.out_z = batch[ord[k]].z;
				o.out_depth = batch_key[ord[k]];
				o.is_last = (k == n - 1);
				sorted_q.push_back(o);
			end
			if (n > 0) flushes++;
			batch.delete();
			batch_key.delete();
		end
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx <= REG_VIEW_Z) begin
			if (idx < REG_VIEW_X) cam[idx] = val;
			else view[idx - REG_VIEW_X] = val;
		end
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// returns at the falling edge after acceptance with valid still high;
	// the next send replaces the item or drops valid, and drain drops it
	task automatic send(input in_item_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict(it);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sorted_q.size() != 0) @(posedge clk);
		// an accepted add still keeps the block busy after the queue is empty
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t rand_add();
		in_item_t it;
		it.action = ACT_ADD;
		it.sprite_kind = 8'($urandom);
		it.sprite_alpha = 8'($urandom);
		it.pos_x = rand_word();
		it.pos_y = rand_word();
		// narrow z sometimes to make equal keys likely
		it.pos_z = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) << 16 : rand_word();
		return it;
	endfunction

	// result side: random stalls, check against the oldest expectation
	initial begin
		int stall;
		out_item_t exp_o;
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			@(negedge clk);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sprites_out++;
			if (sorted_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected sprite %p", $time, out_data);
			end else begin
				exp_o = sorted_q.pop_front();
				if (out_data !== exp_o) begin
					errors++;
					$display("%0t: expected %p actual %p", $time, exp_o, out_data);
				end
			end
		end
	end

	typedef struct {
		in_item_t it;
		bit has_exp;
		out_item_t exp_o;
	} step_t;

	initial begin
		step_t steps [$];
		step_t s;
		in_item_t it;
		int cnt;
		cam = '{default: 32'd0};
		view = '{32'd0, 32'd0, 32'd65536};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: after reset key = -(z>>>7 * 512 >>>2) = -z with view_z = 1.0
		s.has_exp = 1'b0;
		s.it = '{ACT_FLUSH, 8'h00, 8'h00, 32'd0, 32'd0, 32'd0}; steps.push_back(s);
		s.it = '{ACT_ADD, 8'hff, 8'h00, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
		s.has_exp = 1'b1;
		s.exp_o = '{8'hff, 8'h00, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
			32'hffff_0000, 1'b0};
		steps.push_back(s);
		s.it = '{ACT_ADD, 8'h00, 8'hff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000};
		s.exp_o = '{8'h00, 8'hff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000,
			32'h0001_0000, 1'b0};
		steps.push_back(s);
		s.has_exp = 1'b0;
		s.it = '{ACT_ADD, 8'h11, 8'h22, 32'd5, 32'd6, 32'h0001_0000}; steps.push_back(s);
		s.it = '{ACT_ADD, 8'h33, 8'h44, 32'd7, 32'd8, 32'h0001_0000}; steps.push_back(s);
		s.it = '{ACT_FLUSH, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
		steps.push_back(s);
		s.it = '{ACT_FLUSH, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
		steps.push_back(s);
		foreach (steps[i]) begin
			// note: directed expectations only check the predicted depth key;
			// the predictor supplies the sorted queue that is checked
			if (steps[i].has_exp) begin
				if (depth_key(steps[i].it) !== steps[i].exp_o.out_depth) begin
					errors++;
					$display("%0t: expected %h actual %h", $time,
						steps[i].exp_o.out_depth, depth_key(steps[i].it));
				end
			end
			send(steps[i].it);
		end
		drain();

		// store full: 65 adds, the last two dropped
		for (int i = 0; i < 65; i++) send(rand_add());
		it = rand_add(); it.action = ACT_FLUSH; send(it);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < 6; r++) begin
				case (ph)
					0: reg_write(3'(r), 32'h8000_0000);
					1: reg_write(3'(r), 32'h7fff_ffff);
					2: reg_write(3'(r), 32'd0);
					default: reg_write(3'(r), rand_word());
				endcase
			end
			if (ph == 3) reg_write(3'd6, $urandom); // out of range, ignored
			if (ph == 4) reg_write(3'd7, $urandom);
			cnt = 0;
			while (cnt < 65) begin
				it = rand_add();
				if ($urandom_range(0, 5) == 0) begin
					it.action = ACT_FLUSH;
				end
				send(it);
				cnt++;
			end
			it.action = ACT_FLUSH; send(it);
			drain();
		end
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		$display("covered %0d non-empty flushes, %0d sprites out, all six registers at extremes",
			flushes, sprites_out);
		if (errors == 0 && sorted_q.size() == 0) begin
			$display("transparent_sprite_depth_sorter: match");
		end else begin
			$display("transparent_sprite_depth_sorter: mismatch");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("transparent_sprite_depth_sorter: mismatch");
		$finish;
	end
endmodule
